// ===== rtl/core/bmhf_pkg.sv =====
// Shared types and constants for the binary majority hole fill block.
// Used by every file of the block but the input channel interface; depends on nothing.
`default_nettype none

package bmhf_pkg;

   localparam int MaxWidth = 4096;
   localparam int ColBits = $clog2(MaxWidth);
   localparam int RowBits = 16;
   localparam int WidthRegBits = 13;
   localparam int ThreshBits = 4;
   localparam int CsrIdxBits = 2;
   localparam int CsrDataBits = 16;
   localparam int CountBits = 4;

   typedef logic [ColBits-1:0] col_type;
   typedef logic [RowBits-1:0] row_type;
   typedef logic [ThreshBits-1:0] thresh_type;
   typedef logic [CsrIdxBits-1:0] csr_idx_type;
   typedef logic [CsrDataBits-1:0] csr_data_type;

   localparam csr_idx_type CSR_FRAME_WIDTH = 2'd0;
   localparam csr_idx_type CSR_FRAME_HEIGHT = 2'd1;
   localparam csr_idx_type CSR_MIN_TRUE = 2'd2;

   localparam col_type RST_WIDTH_M1 = col_type'(1023);
   localparam row_type RST_HEIGHT_M1 = row_type'(1023);
   localparam thresh_type RST_THRESH = thresh_type'(5);

   // One image column of the 3x3 window: rows r-1, r, r+1 relative to the result.
   typedef logic [2:0] triple_type;
   localparam int TRI_TOP = 0;
   localparam int TRI_MID = 1;
   localparam int TRI_BOT = 2;

   // Line store word: pixel of the row above and of the row two above.
   typedef logic [1:0] store_type;
   localparam int STORE_TOP = 0;
   localparam int STORE_MID = 1;

   typedef struct packed {
      logic first_row;
      logic last_row;
      logic first_col;
      logic last_col;
   } border_type;

   typedef struct packed {
      row_type    row;
      col_type    col;
      logic       last;
      border_type border;
   } out_pos_type;

endpackage

`default_nettype wire

// ===== rtl/core/bmhf_req_if.sv =====
// Input channel of the hole fill block: one pixel word per handshake.
// Depends on nothing.
`default_nettype none

interface bmhf_req_if;
   logic valid;
   logic ready;
   logic pixel_in;
   logic pad_item;

   modport source (output valid, output pixel_in, output pad_item, input ready);
   modport sink (input valid, input pixel_in, input pad_item, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bmhf_rsp_if.sv =====
// Result channel of the hole fill block: one filled pixel word per handshake.
// Depends on bmhf_pkg for the row and column types.
`default_nettype none

interface bmhf_rsp_if;
   logic             valid;
   logic             ready;
   logic             pixel_out;
   bmhf_pkg::row_type row_out;
   bmhf_pkg::col_type col_out;
   logic             frame_done;

   modport source (output valid, output pixel_out, output row_out, output col_out,
                   output frame_done, input ready);
   modport sink (input valid, input pixel_out, input row_out, input col_out,
                 input frame_done, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bmhf_line_store.sv =====
// Two-row line store: one word per column, single write port, registered read.
// Depends on bmhf_pkg.
`default_nettype none

module bmhf_line_store (
   input  wire logic                clock,
   input  wire logic                rd_en,
   input  wire bmhf_pkg::col_type   rd_addr,
   output      bmhf_pkg::store_type rd_data,
   input  wire logic                wr_en,
   input  wire bmhf_pkg::col_type   wr_addr,
   input  wire bmhf_pkg::store_type wr_data
);

   bmhf_pkg::store_type mem [bmhf_pkg::MaxWidth];
   bmhf_pkg::store_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // A one-column frame reads the column that is being written in the same cycle.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/bmhf_cell.sv =====
// One column cell of the 3x3 window; hands its column to the left neighbor.
// Depends on bmhf_pkg.
`default_nettype none

module bmhf_cell (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 shift_en,
   input  wire bmhf_pkg::triple_type triple_in,
   output      bmhf_pkg::triple_type triple_out
);

   bmhf_pkg::triple_type triple_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         triple_ff <= '0;
      end else if (shift_en) begin
         triple_ff <= triple_in;
      end
   end

   assign triple_out = triple_ff;

endmodule

`default_nettype wire

// ===== rtl/core/bmhf_window.sv =====
// 3x3 window built from a chain of three column cells, plus the fill decision.
// Depends on bmhf_pkg and bmhf_cell.
`default_nettype none

module bmhf_window (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 shift_en,
   input  wire bmhf_pkg::triple_type triple_in,
   input  wire bmhf_pkg::border_type border,
   input  wire bmhf_pkg::thresh_type min_true,
   output      logic                 fill_out
);

   bmhf_pkg::triple_type cells [3];
   bmhf_pkg::triple_type chain_in [3];
   bmhf_pkg::triple_type masked [3];
   logic [bmhf_pkg::CountBits-1:0] count;

   // Cell 2 takes the newest column; cell 0 holds the oldest (left) column.
   assign chain_in[2] = triple_in;
   assign chain_in[1] = cells[2];
   assign chain_in[0] = cells[1];

   for (genvar i = 0; i < 3; i++) begin : g_cell
      bmhf_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (shift_en),
         .triple_in  (chain_in[i]),
         .triple_out (cells[i])
      );
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         masked[i] = cells[i];
         if (border.first_row) begin
            masked[i][bmhf_pkg::TRI_TOP] = 1'b0;
         end
         if (border.last_row) begin
            masked[i][bmhf_pkg::TRI_BOT] = 1'b0;
         end
      end
      if (border.first_col) begin
         masked[0] = '0;
      end
      if (border.last_col) begin
         masked[2] = '0;
      end
   end

   always_comb begin
      count = '0;
      for (int i = 0; i < 3; i++) begin
         count = count + bmhf_pkg::CountBits'(masked[i][bmhf_pkg::TRI_TOP]);
         count = count + bmhf_pkg::CountBits'(masked[i][bmhf_pkg::TRI_BOT]);
      end
      count = count + bmhf_pkg::CountBits'(masked[0][bmhf_pkg::TRI_MID]);
      count = count + bmhf_pkg::CountBits'(masked[2][bmhf_pkg::TRI_MID]);
   end

   assign fill_out = cells[1][bmhf_pkg::TRI_MID] | (count >= min_true);

endmodule

`default_nettype wire

// ===== rtl/core/binary_majority_hole_fill.sv =====
// Binary majority hole fill, top level. Depends on bmhf_pkg, the two channel
// interfaces, bmhf_line_store and bmhf_window.
// Pixels enter on req_if in raster order, one word per cycle at most. A FALSE
// pixel leaves on rsp_if as TRUE when at least min_true_neighbors of its eight
// neighbors are TRUE; neighbors outside the frame count as FALSE. Each result
// belongs to the word sent frame_width + 1 words earlier, so the host sends
// that many pad words after a frame; the word that completes a result passes
// stage 1, stage 2 and the output register before it shows on rsp_if. The
// sustained rate is one word per cycle while rsp_if takes results, set by the
// line store, which reads one column and writes another in the same cycle.
// Up to three words sit in the pipeline, so req_if stays ready while a result
// waits; a stalled rsp_if fills the stages and then drops req_if.ready.
// csr_we writes frame_width, frame_height or min_true_neighbors; a geometry
// write restarts the frame. Write only while the block is idle.
// Reset restores the default geometry (1024 x 1024, threshold 5) and empties
// the pipeline. The line store is not cleared: entries left from before a
// frame only reach window positions that lie outside the frame and are masked.
`default_nettype none

module binary_majority_hole_fill (
   input  wire logic                   clock,
   input  wire logic                   reset,
   bmhf_req_if.sink                    req_if,
   bmhf_rsp_if.source                  rsp_if,
   input  wire logic                   csr_we,
   input  wire bmhf_pkg::csr_idx_type  csr_index,
   input  wire bmhf_pkg::csr_data_type csr_wdata
);

   // Configuration; width and height are held as effective size minus one.
   bmhf_pkg::col_type    width_m1_ff, width_m1_in;
   bmhf_pkg::row_type    height_m1_ff, height_m1_in;
   bmhf_pkg::thresh_type thresh_ff, thresh_in;

   bmhf_pkg::col_type in_col_ff, in_col_in;
   bmhf_pkg::row_type in_row_ff, in_row_in;
   bmhf_pkg::col_type out_col_ff, out_col_in;
   bmhf_pkg::row_type out_row_ff, out_row_in;

   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_pix_ff;
   logic                  s1_emit_ff;
   bmhf_pkg::col_type     s1_addr_ff;
   bmhf_pkg::out_pos_type s1_pos_ff;

   logic                  s2_valid_ff, s2_valid_in;
   bmhf_pkg::out_pos_type s2_pos_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_pixel_ff;
   bmhf_pkg::row_type rsp_row_ff;
   bmhf_pkg::col_type rsp_col_ff;
   logic              rsp_done_ff;

   logic                  accept;
   logic                  out_load;
   logic                  s2_free;
   logic                  s1_move;
   logic                  pix0;
   logic                  emit0;
   logic                  last0;
   bmhf_pkg::out_pos_type pos0;
   bmhf_pkg::store_type   rd_word;
   bmhf_pkg::store_type   wr_word;
   bmhf_pkg::triple_type  triple;
   logic                  fill;
   logic                  geom_write;
   logic [bmhf_pkg::WidthRegBits-1:0] wr_width;
   bmhf_pkg::row_type     wr_height;

   // Pipeline flow: each stage moves on when the one after it has room.
   assign out_load = s2_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign s2_free  = !s2_valid_ff || out_load;
   assign s1_move  = s1_valid_ff && s2_free;
   assign req_if.ready = !s1_valid_ff || s1_move;
   assign accept = req_if.valid && req_if.ready;

   // Stage 0: input position, result position and pixel of the accepted word.
   assign pix0 = req_if.pixel_in & ~req_if.pad_item & (in_row_ff <= height_m1_ff);
   assign emit0 = (in_row_ff >= bmhf_pkg::row_type'(2))
                  || ((in_row_ff == bmhf_pkg::row_type'(1)) && (in_col_ff != '0));
   assign last0 = (out_row_ff >= height_m1_ff) && (out_col_ff >= width_m1_ff);

   always_comb begin
      pos0.row = out_row_ff;
      pos0.col = out_col_ff;
      pos0.last = last0;
      pos0.border.first_row = (out_row_ff == '0);
      pos0.border.last_row  = (out_row_ff >= height_m1_ff);
      pos0.border.first_col = (out_col_ff == '0);
      pos0.border.last_col  = (out_col_ff >= width_m1_ff);
   end

   assign geom_write = csr_we && ((csr_index == bmhf_pkg::CSR_FRAME_WIDTH)
                                 || (csr_index == bmhf_pkg::CSR_FRAME_HEIGHT));
   assign wr_width  = csr_wdata[bmhf_pkg::WidthRegBits-1:0];
   assign wr_height = csr_wdata[bmhf_pkg::RowBits-1:0];

   always_comb begin
      width_m1_in  = width_m1_ff;
      height_m1_in = height_m1_ff;
      thresh_in    = thresh_ff;
      if (csr_we) begin
         unique case (csr_index)
            bmhf_pkg::CSR_FRAME_WIDTH: begin
               if (wr_width == '0) begin
                  width_m1_in = '0;
               end else if (wr_width > bmhf_pkg::WidthRegBits'(bmhf_pkg::MaxWidth)) begin
                  width_m1_in = bmhf_pkg::col_type'(bmhf_pkg::MaxWidth - 1);
               end else begin
                  width_m1_in = bmhf_pkg::col_type'(wr_width - 1'b1);
               end
            end
            bmhf_pkg::CSR_FRAME_HEIGHT: begin
               height_m1_in = (wr_height == '0) ? '0 : wr_height - 1'b1;
            end
            bmhf_pkg::CSR_MIN_TRUE: begin
               thresh_in = csr_wdata[bmhf_pkg::ThreshBits-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (geom_write) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (accept) begin
         if (in_col_ff >= width_m1_ff) begin
            in_col_in = '0;
            if (in_row_ff != '1) begin
               in_row_in = in_row_ff + 1'b1;
            end
         end else begin
            in_col_in = in_col_ff + 1'b1;
         end
         // The last result of a frame restarts both input and result positions.
         if (emit0) begin
            if (last0) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (out_col_ff >= width_m1_ff) begin
               out_col_in = '0;
               out_row_in = out_row_ff + 1'b1;
            end else begin
               out_col_in = out_col_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_m1_ff  <= bmhf_pkg::RST_WIDTH_M1;
         height_m1_ff <= bmhf_pkg::RST_HEIGHT_M1;
         thresh_ff    <= bmhf_pkg::RST_THRESH;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
      end else begin
         width_m1_ff  <= width_m1_in;
         height_m1_ff <= height_m1_in;
         thresh_ff    <= thresh_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
      end
   end

   // Stage 1: the line store word of this column arrives; it is rewritten
   // when the word moves on to the window.
   assign s1_valid_in = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff  <= pix0;
         s1_emit_ff <= emit0;
         s1_addr_ff <= in_col_ff;
         s1_pos_ff  <= pos0;
      end
   end

   bmhf_line_store u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (in_col_ff),
      .rd_data (rd_word),
      .wr_en   (s1_move),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_word)
   );

   always_comb begin
      wr_word = '0;
      wr_word[bmhf_pkg::STORE_MID] = s1_pix_ff;
      wr_word[bmhf_pkg::STORE_TOP] = rd_word[bmhf_pkg::STORE_MID];
      triple = '0;
      triple[bmhf_pkg::TRI_TOP] = rd_word[bmhf_pkg::STORE_TOP];
      triple[bmhf_pkg::TRI_MID] = rd_word[bmhf_pkg::STORE_MID];
      triple[bmhf_pkg::TRI_BOT] = s1_pix_ff;
   end

   // Stage 2: every word shifts the window; only result words make it valid.
   assign s2_valid_in = s1_move ? s1_emit_ff : (out_load ? 1'b0 : s2_valid_ff);

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_pos_ff <= s1_pos_ff;
      end
   end

   bmhf_window u_window (
      .clock     (clock),
      .reset     (reset),
      .shift_en  (s1_move),
      .triple_in (triple),
      .border    (s2_pos_ff.border),
      .min_true  (thresh_ff),
      .fill_out  (fill)
   );

   // Output register.
   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_pixel_ff <= fill;
         rsp_row_ff   <= s2_pos_ff.row;
         rsp_col_ff   <= s2_pos_ff.col;
         rsp_done_ff  <= s2_pos_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.pixel_out  = rsp_pixel_ff;
   assign rsp_if.row_out    = rsp_row_ff;
   assign rsp_if.col_out    = rsp_col_ff;
   assign rsp_if.frame_done = rsp_done_ff;

endmodule

`default_nettype wire
